### design/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg: shared types and constants for the varint stream decoder
// Lead byte masks and patterns, follow-up lengths, status codes, result type.
// ----------------------------------------------------------------------------
package vsd_pkg;

   localparam int unsigned ValueWidth = 64;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned LeftWidth  = 4;

   // lead byte classes: (byte & mask) == pattern
   localparam logic [7:0] Mask1     = 8'h80;
   localparam logic [7:0] Mask2     = 8'hc0;
   localparam logic [7:0] Mask3     = 8'he0;
   localparam logic [7:0] Mask4     = 8'hf0;
   localparam logic [7:0] MaskLong  = 8'hfc;
   localparam logic [7:0] Pat1      = 8'h00;
   localparam logic [7:0] Pat2      = 8'h80;
   localparam logic [7:0] Pat3      = 8'hc0;
   localparam logic [7:0] Pat4      = 8'he0;
   localparam logic [7:0] Pat32     = 8'hf0;
   localparam logic [7:0] Pat64     = 8'hf4;
   localparam logic [7:0] PatInvert = 8'hf8;

   // payload masks of the lead byte
   localparam logic [7:0] Keep7 = 8'h7f;
   localparam logic [7:0] Keep6 = 8'h3f;
   localparam logic [7:0] Keep5 = 8'h1f;
   localparam logic [7:0] Keep4 = 8'h0f;
   localparam logic [7:0] Keep2 = 8'h03;

   // follow-up bytes after each multi-byte lead
   localparam logic [LeftWidth-1:0] Follow2  = 4'd1;
   localparam logic [LeftWidth-1:0] Follow3  = 4'd2;
   localparam logic [LeftWidth-1:0] Follow4  = 4'd3;
   localparam logic [LeftWidth-1:0] Follow32 = 4'd4;
   localparam logic [LeftWidth-1:0] Follow64 = 4'd8;

   localparam logic [CountWidth-1:0] CountMax = 4'd15;

   localparam logic StatusOk        = 1'b0;
   localparam logic StatusTruncated = 1'b1;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic [CountWidth-1:0] byte_count;
      logic                  status;
   } result_type;

endpackage

### design/varint_stream_decoder.sv
// ----------------------------------------------------------------------------
// varint_stream_decoder: prefix-length variable integer decoder
// Decodes a byte stream, one byte per transfer, into signed 64-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one raw byte per transfer in req_tdata[7:0]; req_tlast marks
//   the last byte available in the buffer. rsp_ carries one result per
//   completed code: value and byte count in rsp_tdata, status in rsp_tuser
//   (0 ok, 1 buffer ended inside a code, value then 0).
//   Most bytes produce no result; the result of the byte that completes (or
//   truncates) its code is registered in the output register, or in the skid register while rsp_ stalls.
//   Throughput is one byte per cycle while req_tready is high. All decode work is a mask, compare and
//   8-bit shift into the accumulator between the decoder state and the
//   output register. A two-entry output stage (output register plus skid
//   register) keeps req_tready high while one result waits; req_tready drops
//   only when both entries hold results.
//   Reset (synchronous, active high) returns the decoder to idle with no open
//   code and empties the output stage.
// ----------------------------------------------------------------------------
module varint_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] value, [67:64] byte_count, [71:68] zero
   output logic        rsp_tuser    // status
);
   import vsd_pkg::*;

   // decoder state
   logic [ValueWidth-1:0] acc_ff, acc_in;
   logic [LeftWidth-1:0]  left_ff, left_in;
   logic                  parity_ff, parity_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  in_code_ff, in_code_in;

   // output stage
   result_type out_ff, skid_ff, res;
   logic       out_valid_ff, skid_valid_ff;
   logic       res_valid;

   logic                  accept;
   logic [7:0]            b;
   logic [CountWidth-1:0] cnt;
   logic [ValueWidth-1:0] shifted;
   logic                  lead;
   logic                  done;
   logic [ValueWidth-1:0] done_value;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign cnt        = (count_ff == CountMax) ? CountMax : count_ff + 1'b1;
   assign shifted    = {acc_ff[ValueWidth-9:0], b};
   assign lead       = !in_code_ff || (left_ff == '0);

   always_comb begin
      acc_in     = acc_ff;
      left_in    = left_ff;
      parity_in  = parity_ff;
      count_in   = count_ff;
      in_code_in = in_code_ff;
      done       = 1'b0;
      done_value = '0;
      res_valid  = 1'b0;
      res        = '{value: '0, byte_count: cnt, status: StatusOk};

      if (lead) begin
         if ((b & Mask1) == Pat1) begin
            done       = 1'b1;
            done_value = {{(ValueWidth-8){1'b0}}, b & Keep7};
         end else begin
            if ((b & Mask2) == Pat2) begin
               acc_in  = {{(ValueWidth-8){1'b0}}, b & Keep6};
               left_in = Follow2;
            end else if ((b & Mask3) == Pat3) begin
               acc_in  = {{(ValueWidth-8){1'b0}}, b & Keep5};
               left_in = Follow3;
            end else if ((b & Mask4) == Pat4) begin
               acc_in  = {{(ValueWidth-8){1'b0}}, b & Keep4};
               left_in = Follow4;
            end else if ((b & MaskLong) == Pat32) begin
               acc_in  = '0;
               left_in = Follow32;
            end else if ((b & MaskLong) == Pat64) begin
               acc_in  = '0;
               left_in = Follow64;
            end else if ((b & MaskLong) == PatInvert) begin
               parity_in = !parity_ff;
               acc_in    = '0;
               left_in   = '0;
            end else begin
               // short negative form
               done       = 1'b1;
               done_value = ~{{(ValueWidth-8){1'b0}}, b & Keep2};
            end
            if (!done) begin
               in_code_in = 1'b1;
               count_in   = cnt;
            end
         end
      end else begin
         acc_in   = shifted;
         left_in  = left_ff - 1'b1;
         count_in = cnt;
         if (left_ff == Follow2) begin
            done       = 1'b1;
            done_value = shifted;
         end
      end

      if (done) begin
         res_valid = 1'b1;
         res.value = parity_ff ? ~done_value : done_value;
      end else if (req_tlast) begin
         res_valid  = 1'b1;
         res.status = StatusTruncated;
      end

      if (res_valid) begin
         acc_in     = '0;
         left_in    = '0;
         parity_in  = 1'b0;
         count_in   = '0;
         in_code_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         left_ff    <= '0;
         parity_ff  <= 1'b0;
         count_ff   <= '0;
         in_code_ff <= 1'b0;
      end else if (accept) begin
         acc_ff     <= acc_in;
         left_ff    <= left_in;
         parity_ff  <= parity_in;
         count_ff   <= count_in;
         in_code_ff <= in_code_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= accept && res_valid;
         out_ff       <= res;
      end else if (accept && res_valid) begin
         skid_ff       <= res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.byte_count, out_ff.value};
   assign rsp_tuser  = out_ff.status;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= Follow64)
      else $error("follow-up count beyond the longest form");

   a_left_needs_code: assert property (@(posedge clock) disable iff (reset)
      (left_ff != '0) |-> in_code_ff)
      else $error("follow-up bytes expected with no open code");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_code_ff |-> (!parity_ff && count_ff == '0))
      else $error("idle decoder carries parity or byte count");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && req_tready))
      else $error("output stage not empty after reset");

endmodule

### test/varint_result_checker.sv
// ----------------------------------------------------------------------------
// varint_result_checker: scoreboard for the varint stream decoder
// Watches both stream channels, decodes every accepted byte with its own
// decoder state, and compares each result transfer with the oldest decoded
// result still outstanding.
// ----------------------------------------------------------------------------
module varint_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // buffer_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // [63:0] value, [67:64] byte_count, [71:68] zero
   input  logic        rsp_tuser,   // status
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          truncated
);
   import vsd_pkg::*;

   result_type decoded_q[$];

   logic [ValueWidth-1:0] acc;
   logic [LeftWidth-1:0]  left_count;
   logic [CountWidth-1:0] seen_count;
   logic                  flip;
   logic                  open_code;

   int mismatches = 0;
   int results_seen = 0;
   int trunc_seen = 0;

   task automatic clear_code();
      acc        = '0;
      left_count = '0;
      seen_count = '0;
      flip       = 1'b0;
      open_code  = 1'b0;
   endtask

   // one byte into the decoder; queues the result it completes, if any
   task automatic decode_byte(input logic [7:0] b, input logic last);
      result_type            r;
      logic [CountWidth-1:0] n;
      logic                  done;
      n    = (seen_count < CountMax) ? seen_count + 1'b1 : CountMax;
      done = 1'b0;
      r    = '0;
      if (!open_code || left_count == 0) begin
         if ((b & Mask1) == Pat1) begin
            r.value = ValueWidth'(b & Keep7);
            done = 1'b1;
         end else if ((b & Mask2) == Pat2) begin
            acc = ValueWidth'(b & Keep6);
            left_count = Follow2;
         end else if ((b & Mask3) == Pat3) begin
            acc = ValueWidth'(b & Keep5);
            left_count = Follow3;
         end else if ((b & Mask4) == Pat4) begin
            acc = ValueWidth'(b & Keep4);
            left_count = Follow4;
         end else if ((b & MaskLong) == Pat32) begin
            acc = '0;
            left_count = Follow32;
         end else if ((b & MaskLong) == Pat64) begin
            acc = '0;
            left_count = Follow64;
         end else if ((b & MaskLong) == PatInvert) begin
            flip = ~flip;
            acc = '0;
            left_count = '0;
         end else begin
            r.value = ~ValueWidth'(b & Keep2);
            done = 1'b1;
         end
         if (!done) begin
            open_code  = 1'b1;
            seen_count = n;
         end
      end else begin
         acc        = {acc[ValueWidth-9:0], b};
         left_count = left_count - 1'b1;
         seen_count = n;
         if (left_count == 0) begin
            r.value = acc;
            done = 1'b1;
         end
      end
      if (done) begin
         if (flip)
            r.value = ~r.value;
         r.byte_count = n;
         r.status     = StatusOk;
         decoded_q.push_back(r);
         clear_code();
      end else if (last) begin
         // buffer ran out inside an open code
         r.value      = '0;
         r.byte_count = seen_count;
         r.status     = StatusTruncated;
         decoded_q.push_back(r);
         clear_code();
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_code();
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected result transfer, got value %h count %0d status %0d",
                        $time, rsp_tdata[63:0], rsp_tdata[67:64], rsp_tuser);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               results_seen++;
               if (want.status == StatusTruncated)
                  trunc_seen++;
               if (rsp_tdata[63:0] !== want.value) begin
                  $display("%0t: value mismatch, expected %h got %h",
                           $time, want.value, rsp_tdata[63:0]);
                  mismatches++;
               end
               if (rsp_tdata[67:64] !== want.byte_count) begin
                  $display("%0t: byte_count mismatch, expected %0d got %0d",
                           $time, want.byte_count, rsp_tdata[67:64]);
                  mismatches++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status mismatch, expected %0d got %0d",
                           $time, want.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[71:68] !== 4'd0) begin
                  $display("%0t: pad bits mismatch, expected 0 got %h",
                           $time, rsp_tdata[71:68]);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= decoded_q.size();
      checked    <= results_seen;
      truncated  <= trunc_seen;
   end

endmodule

### test/tb_varint_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_varint_stream_decoder: testbench for the varint stream decoder
// Drives directed codes and then random well-formed, broken and noise byte
// streams under four sender idle / receiver stall mixes; a checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_varint_stream_decoder;
   import vsd_pkg::*;

   localparam int QuietLimit = 1000;
   localparam int ByteTarget = 650;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;

   int fail_count;
   int pending;
   int checked;
   int truncated;

   int send_idle = 0;
   int recv_stall = 0;
   int sent_bytes = 0;
   int quiet_cycles = 0;

   int send_mix[4] = '{0, 54, 0, 26};
   int stall_mix[4] = '{0, 0, 54, 26};

   varint_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   varint_result_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .truncated  (truncated)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("timeout: no transfer for %0d cycles", QuietLimit);
         $display("varint_stream_decoder verification failed");
         $finish;
      end
   end

   task automatic put_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_bytes++;
   endtask

   // hold off the sender until every queued result has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // one code: optional invert prefixes, a lead byte, its follow-up bytes;
   // buffer_end now and then lands inside it, some items are pure noise
   task automatic send_code();
      int unsigned prefixes;
      int unsigned follow;
      int unsigned pick;
      logic [7:0]  lead;
      logic [7:0]  low;
      pick = $urandom_range(99);
      if (pick < 8) begin
         put_byte(8'($urandom), 1'($urandom_range(1)));
      end else begin
         pick = $urandom_range(99);
         if (pick < 70)
            prefixes = 0;
         else if (pick < 92)
            prefixes = $urandom_range(3, 1);
         else
            prefixes = $urandom_range(18, 12);
         for (int i = 0; i < prefixes; i++)
            put_byte(PatInvert | (8'($urandom) & Keep2), ($urandom_range(39) == 0));
         low = 8'($urandom);
         case ($urandom_range(6))
            0: begin lead = Pat1 | (low & Keep7);     follow = 0; end
            1: begin lead = Pat2 | (low & Keep6);     follow = 1; end
            2: begin lead = Pat3 | (low & Keep5);     follow = 2; end
            3: begin lead = Pat4 | (low & Keep4);     follow = 3; end
            4: begin lead = Pat32 | (low & Keep2);    follow = 4; end
            5: begin lead = Pat64 | (low & Keep2);    follow = 8; end
            default: begin lead = MaskLong | (low & Keep2); follow = 0; end
         endcase
         if (follow == 0) begin
            put_byte(lead, ($urandom_range(99) < 15));
         end else begin
            put_byte(lead, ($urandom_range(39) == 0));
            for (int i = 1; i < follow; i++)
               put_byte(8'($urandom), ($urandom_range(39) == 0));
            put_byte(8'($urandom), ($urandom_range(99) < 15));
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: payload extremes of every form but the 64-bit one, short negatives,
      // invert prefixes, truncation and buffer_end after a complete code
      put_byte(Pat1, 1'b0);
      put_byte(Keep7, 1'b0);
      put_byte(Pat2 | Keep6, 1'b0);
      put_byte(8'hff, 1'b0);
      put_byte(Pat3 | Keep5, 1'b0);
      put_byte(8'hff, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(Pat4 | Keep4, 1'b0);
      put_byte(8'h12, 1'b0);
      put_byte(8'h34, 1'b0);
      put_byte(8'h56, 1'b0);
      put_byte(Pat32 | Keep2, 1'b0);   // low bits of follow-up leads ignored
      repeat (4) put_byte(8'hff, 1'b0);
      put_byte(MaskLong, 1'b0);
      put_byte(MaskLong | Keep2, 1'b0);
      put_byte(PatInvert, 1'b0);
      put_byte(8'h05, 1'b0);
      put_byte(PatInvert | Keep2, 1'b0);
      put_byte(PatInvert | 8'h01, 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(Pat2, 1'b1);            // ends inside a code
      put_byte(PatInvert, 1'b1);       // ends after a lone prefix
      put_byte(8'h05, 1'b1);           // ends right after a complete code
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = send_mix[ph];
         recv_stall = stall_mix[ph];
         while (sent_bytes < (ph + 1) * ByteTarget / 4 + 25)
            send_code();
         drain();
      end

      repeat (8) @(posedge clock);
      $display("run covered %0d bytes and %0d results (%0d truncated)",
               sent_bytes, checked, truncated);
      $display("across directed codes and four sender idle / receiver stall mixes");
      if (fail_count == 0)
         $display("varint_stream_decoder verification clean");
      else
         $display("varint_stream_decoder verification failed");
      $finish;
   end

endmodule
